@@ hw/rtl/ille_pkg.sv @@
package ille_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 7;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic [FUNC_W-1:0] FN_ADD_FRONT    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD_BACK     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT       = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE_FRONT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REMOVE_BACK  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ         = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_LOAD_TAP,
        CO_SHIFT_TAP,
        CO_INSERT,
        CO_POP_FRONT
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic [CMP_W-1:0]     pos;
        logic [VALUE_W-1:0]   item;
    } t_cell_ctl;

endpackage

@@ hw/rtl/ille_req_if.sv @@
interface ille_req_if import ille_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic signed [VALUE_W-1:0]  item_value;
    logic [POS_W-1:0]           position;

    modport source (output valid, func, item_value, position, input ready);
    modport sink   (input valid, func, item_value, position, output ready);
endinterface

@@ hw/rtl/ille_rsp_if.sv @@
interface ille_rsp_if import ille_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0]        status;
    logic [CNT_W-1:0]           count;

    modport source (output valid, read_value, status, count, input ready);
    modport sink   (input valid, read_value, status, count, output ready);
endinterface

@@ hw/rtl/indexed_linked_list_engine_unit.sv @@
// channel   modport  handshake      payload
// i_req     sink     valid/ready    func, item_value, position
// o_rsp     source   valid/ready    read_value, status, count
//
// Elements sit in a row of cells in list order; inserts and front removals
// shift the row by one cell.
// Reads and removals walk a tap register toward cell 0, one cell a cycle,
// starting from the requested index (tail removal uses length - 1).
// Adds, inserts and rejected requests skip the walk and go straight to emit.
// Synchronous active-low reset empties the list; cell contents are not reset.
// A result held on o_rsp stalls the next result, which then blocks acceptance.
module indexed_linked_list_engine_unit import ille_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ille_req_if.sink    i_req,
    ille_rsp_if.source  o_rsp
);

    t_cell_ctl           w_ctl;
    logic [VALUE_W-1:0]  w_value [CAPACITY];
    logic [VALUE_W-1:0]  w_tap   [CAPACITY];

    ille_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .o_req_ready  (i_req.ready),
        .i_func       (i_req.func),
        .i_item       (i_req.item_value),
        .i_position   (i_req.position),
        .i_tap        (w_tap[0]),
        .o_ctl        (w_ctl),
        .o_rsp_valid  (o_rsp.valid),
        .i_rsp_ready  (o_rsp.ready),
        .o_read_value (o_rsp.read_value),
        .o_status     (o_rsp.status),
        .o_count      (o_rsp.count)
    );

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [VALUE_W-1:0] w_prev;
        logic [VALUE_W-1:0] w_next;
        logic [VALUE_W-1:0] w_next_tap;

        if (gi == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_value[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign w_next     = '0;
            assign w_next_tap = '0;
        end else begin : g_inner
            assign w_next     = w_value[gi+1];
            assign w_next_tap = w_tap[gi+1];
        end

        ille_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_index      (IDX_W'(gi)),
            .i_prev_value (w_prev),
            .i_next_value (w_next),
            .i_next_tap   (w_next_tap),
            .o_value      (w_value[gi]),
            .o_tap        (w_tap[gi])
        );
    end

endmodule

@@ hw/rtl/ille_cell.sv @@
module ille_cell import ille_pkg::*; (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [IDX_W-1:0]   i_index,
    input  logic [VALUE_W-1:0] i_prev_value,
    input  logic [VALUE_W-1:0] i_next_value,
    input  logic [VALUE_W-1:0] i_next_tap,
    output logic [VALUE_W-1:0] o_value,
    output logic [VALUE_W-1:0] o_tap
);

    logic [VALUE_W-1:0] r_value, n_value;
    logic [VALUE_W-1:0] r_tap, n_tap;
    logic [CMP_W-1:0]   w_index;

    assign w_index = CMP_W'(i_index);

    always_comb begin
        n_value = r_value;
        n_tap   = r_tap;
        unique case (i_ctl.op)
            CO_LOAD_TAP: begin
                n_tap = (w_index == i_ctl.pos) ? r_value : '0;
            end
            CO_SHIFT_TAP: begin
                n_tap = i_next_tap;
            end
            CO_INSERT: begin
                if (w_index == i_ctl.pos) begin
                    n_value = i_ctl.item;
                end else if (w_index > i_ctl.pos) begin
                    n_value = i_prev_value;
                end
            end
            CO_POP_FRONT: begin
                n_value = i_next_value;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_tap   <= n_tap;
    end

    assign o_value = r_value;
    assign o_tap   = r_tap;

endmodule

@@ hw/rtl/ille_ctrl.sv @@
module ille_ctrl import ille_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [VALUE_W-1:0]        i_item,
    input  logic [POS_W-1:0]          i_position,
    input  logic [VALUE_W-1:0]        i_tap,
    output t_cell_ctl                 o_ctl,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_ready,
    output logic signed [VALUE_W-1:0] o_read_value,
    output logic [STATUS_W-1:0]       o_status,
    output logic [CNT_W-1:0]          o_count
);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [FUNC_W-1:0]   r_func;
    logic [VALUE_W-1:0]  r_item;
    logic [CMP_W-1:0]    r_pos;
    logic [STATUS_W-1:0] r_status;
    logic                r_use_tap;
    logic [CMP_W-1:0]    r_walk, n_walk;
    logic                r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic [STATUS_W-1:0] r_out_status;
    logic [CNT_W-1:0]    r_out_count;

    logic                w_accept;
    logic                w_out_free;
    logic                w_full;
    logic                w_empty;
    logic [CMP_W-1:0]    w_cnt;
    logic [CMP_W-1:0]    w_pos;
    logic [STATUS_W-1:0] d_status;
    logic                d_tap;
    logic [CMP_W-1:0]    d_idx;
    logic                w_emit;
    logic                w_grow;
    logic                w_shrink;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_out_free  = !r_out_valid || i_rsp_ready;
    assign w_cnt       = CMP_W'(r_count);
    assign w_pos       = CMP_W'(i_position);
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);

    // request decode against the current length
    always_comb begin
        d_status = ST_OK;
        d_tap    = 1'b0;
        d_idx    = w_pos;
        unique case (i_func)
            FN_ADD_FRONT: begin
                d_idx = '0;
                if (w_full) d_status = ST_FULL;
            end
            FN_ADD_BACK: begin
                d_idx = w_cnt;
                if (w_full) d_status = ST_FULL;
            end
            FN_INSERT: begin
                if (w_pos > w_cnt) begin
                    d_status = ST_RANGE;
                end else if (w_full) begin
                    d_status = ST_FULL;
                end
            end
            FN_REMOVE_FRONT: begin
                d_idx = '0;
                if (w_empty) d_status = ST_EMPTY;
                else         d_tap    = 1'b1;
            end
            FN_REMOVE_BACK: begin
                d_idx = w_cnt - CMP_W'(1);
                if (w_empty) d_status = ST_EMPTY;
                else         d_tap    = 1'b1;
            end
            FN_READ: begin
                if (w_empty) begin
                    d_status = ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    d_status = ST_RANGE;
                end else begin
                    d_tap = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_emit   = (r_state == S_EMIT) && w_out_free;
    assign w_grow   = (r_status == ST_OK) && ((r_func == FN_ADD_FRONT) ||
                      (r_func == FN_ADD_BACK) || (r_func == FN_INSERT));
    assign w_shrink = (r_status == ST_OK) && ((r_func == FN_REMOVE_FRONT) ||
                      (r_func == FN_REMOVE_BACK));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = d_tap ? S_WALK : S_EMIT;
            end
            S_WALK: begin
                if (r_walk == '0) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // cell commands
    always_comb begin
        o_ctl.op   = CO_HOLD;
        o_ctl.pos  = r_pos;
        o_ctl.item = r_item;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.pos = d_idx;
                if (w_accept && d_tap) o_ctl.op = CO_LOAD_TAP;
            end
            S_WALK: begin
                if (r_walk != '0) o_ctl.op = CO_SHIFT_TAP;
            end
            S_EMIT: begin
                if (w_emit && w_grow) begin
                    o_ctl.op = CO_INSERT;
                end else if (w_emit && (r_status == ST_OK) &&
                             (r_func == FN_REMOVE_FRONT)) begin
                    o_ctl.op = CO_POP_FRONT;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_emit && w_grow)        n_count = r_count + CNT_W'(1);
        else if (w_emit && w_shrink) n_count = r_count - CNT_W'(1);
    end

    always_comb begin
        n_walk = r_walk;
        if (w_accept)                                n_walk = d_idx;
        else if (r_state == S_WALK && r_walk != '0)  n_walk = r_walk - CMP_W'(1);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_emit)           n_out_valid = 1'b1;
        else if (i_rsp_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk <= n_walk;
        if (w_accept) begin
            r_func    <= i_func;
            r_item    <= i_item;
            r_pos     <= d_idx;
            r_status  <= d_status;
            r_use_tap <= d_tap;
        end
        if (w_emit) begin
            r_out_value  <= r_use_tap ? i_tap : '0;
            r_out_status <= r_status;
            r_out_count  <= n_count;
        end
    end

    assign o_rsp_valid  = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;

endmodule

@@ hw/rtl/ille_checker.sv @@
module ille_checker import ille_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_rsp_valid,
    input logic                      i_rsp_ready,
    input logic signed [VALUE_W-1:0] i_read_value,
    input logic [STATUS_W-1:0]       i_status,
    input logic [CNT_W-1:0]          i_count
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_read_value) &&
        $stable(i_status) && $stable(i_count))
        else $error("response changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ST_EMPTY) |-> (i_count == '0) && (i_read_value == '0))
        else $error("empty status with nonzero count or value");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ST_FULL) |->
        (i_count == CNT_W'(CAPACITY)) && (i_read_value == '0))
        else $error("full status with count below capacity");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_count <= CNT_W'(CAPACITY)))
        else $error("count above capacity");

endmodule

bind indexed_linked_list_engine_unit ille_checker u_ille_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_read_value (o_rsp.read_value),
    .i_status     (o_rsp.status),
    .i_count      (o_rsp.count)
);

@@ sim/tb_indexed_linked_list_engine_unit.sv @@
module tb_indexed_linked_list_engine_unit import ille_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FUNC_W-1:0] FN_RSVD_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD_B = 3'd7;

    localparam logic [FUNC_W-1:0] GROW_FNS [3] = '{FN_ADD_FRONT, FN_ADD_BACK, FN_INSERT};
    localparam logic [FUNC_W-1:0] SHRINK_FNS [4] =
        '{FN_REMOVE_FRONT, FN_REMOVE_BACK, FN_READ, FN_READ};

    localparam int unsigned SETTLE_CYCLES = 80;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
        logic [CNT_W-1:0]          count;
    } t_list_rsp;

    logic i_clk;
    logic i_rst_n;

    ille_req_if req_ch ();
    ille_rsp_if rsp_ch ();

    indexed_linked_list_engine_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic signed [VALUE_W-1:0] list_contents [$];
    t_list_rsp                 pending_rsp [$];
    int unsigned               err_count;
    int unsigned               hold_left;
    int unsigned               burst_left;
    bit                        send_gaps_en;
    bit                        rsp_stall_en;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic t_list_rsp list_apply(input logic [FUNC_W-1:0] fn,
                                             input logic signed [VALUE_W-1:0] val,
                                             input logic [POS_W-1:0] pos);
        t_list_rsp   r;
        int unsigned len;
        len      = list_contents.size();
        r.value  = '0;
        r.status = ST_OK;
        case (fn)
            FN_ADD_FRONT, FN_ADD_BACK: begin
                if (len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (fn == FN_ADD_FRONT) begin
                    list_contents.push_front(val);
                end else begin
                    list_contents.push_back(val);
                end
            end
            FN_INSERT: begin
                // range is checked ahead of full
                if (pos > len) begin
                    r.status = ST_RANGE;
                end else if (len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_contents.insert(pos, val);
                end
            end
            FN_REMOVE_FRONT: begin
                if (len == 0) r.status = ST_EMPTY;
                else r.value = list_contents.pop_front();
            end
            FN_REMOVE_BACK: begin
                if (len == 0) r.status = ST_EMPTY;
                else r.value = list_contents.pop_back();
            end
            FN_READ: begin
                if (len == 0) r.status = ST_EMPTY;
                else if (pos >= len) r.status = ST_RANGE;
                else r.value = list_contents[pos];
            end
            default: begin
            end
        endcase
        r.count = CNT_W'(list_contents.size());
        return r;
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 11))
            0: return {1'b1, {(VALUE_W-1){1'b0}}};
            1: return {1'b0, {(VALUE_W-1){1'b1}}};
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] rand_pos(input int unsigned span);
        if ($urandom_range(0, 7) == 0) return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        return POS_W'($urandom_range(0, span));
    endfunction

    task automatic send_req(input logic [FUNC_W-1:0] fn,
                            input logic signed [VALUE_W-1:0] val,
                            input logic [POS_W-1:0] pos);
        req_ch.valid      <= 1'b1;
        req_ch.func       <= fn;
        req_ch.item_value <= val;
        req_ch.position   <= pos;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_rsp.push_back(list_apply(fn, val, pos));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (send_gaps_en) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    endtask

    task automatic report_err(input string msg);
        if (err_count < 10) $display("ERROR %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // receiver: own stall pattern, plus a counted hold-off on request
    initial begin : rsp_sink
        logic [15:0] stall_mask;
        int unsigned tick;
        rsp_ch.ready <= 1'b0;
        stall_mask = '0;
        tick       = 0;
        forever begin
            @(posedge i_clk);
            if (tick % 64 == 0) begin
                stall_mask = 16'($urandom_range(0, 1) ? $urandom : ($urandom & $urandom));
            end
            tick++;
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready <= !(rsp_stall_en && stall_mask[tick % 16]);
            end
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_list_rsp exp;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                report_err($sformatf("unexpected transaction value=%0d status=%0d count=%0d",
                                     rsp_ch.read_value, rsp_ch.status, rsp_ch.count));
            end else begin
                exp = pending_rsp.pop_front();
                if (rsp_ch.read_value !== exp.value || rsp_ch.status !== exp.status ||
                    rsp_ch.count !== exp.count) begin
                    report_err($sformatf(
                        "value exp %0d got %0d, status exp %0d got %0d, count exp %0d got %0d",
                        exp.value, rsp_ch.read_value, exp.status, rsp_ch.status,
                        exp.count, rsp_ch.count));
                end
            end
        end
    end

    task automatic test_empty_list();
        send_gaps_en = 1'b1;
        rsp_stall_en = 1'b1;
        send_req(FN_REMOVE_FRONT, 32'sd5, 7'd0);
        send_req(FN_REMOVE_BACK, 32'sd5, 7'd0);
        send_req(FN_READ, '0, 7'd0);
        send_req(FN_READ, '0, 7'd127);
        send_req(FN_INSERT, 32'sd9, 7'd1);
        send_req(FN_RSVD_A, '1, 7'd127);
        send_req(FN_RSVD_B, '1, 7'd0);
        send_req(FN_INSERT, 32'sh7FFF_FFFF, 7'd0);
        send_req(FN_REMOVE_BACK, '0, 7'd0);
        send_req(FN_ADD_BACK, 32'sh8000_0000, 7'd0);
        send_req(FN_REMOVE_FRONT, '0, 7'd0);
        send_req(FN_ADD_FRONT, -32'sd1, 7'd0);
        send_req(FN_READ, '0, 7'd1);
        send_req(FN_READ, '0, 7'd0);
        send_req(FN_REMOVE_FRONT, '0, 7'd0);
    endtask

    task automatic test_insert_positions();
        send_gaps_en = 1'b0;
        rsp_stall_en = 1'b0;
        send_req(FN_ADD_BACK, 32'sd1, 7'd0);
        send_req(FN_ADD_BACK, 32'sd3, 7'd0);
        send_req(FN_INSERT, 32'sd2, 7'd1);
        send_req(FN_INSERT, 32'sh5555_5555, 7'd3);
        send_req(FN_ADD_BACK, 32'sd4, 7'd0);
        send_req(FN_REMOVE_BACK, '0, 7'd0);
        send_req(FN_REMOVE_BACK, '0, 7'd0);
        send_req(FN_INSERT, 32'sd7, 7'd4);
        send_req(FN_INSERT, 32'shAAAA_AAAA, 7'd0);
        send_req(FN_READ, '0, 7'd2);
        send_req(FN_READ, '0, 7'd3);
        send_req(FN_READ, '0, 7'd4);
    endtask

    task automatic test_full_store();
        send_gaps_en = 1'b1;
        rsp_stall_en = 1'b1;
        while (list_contents.size() < CAPACITY) begin
            send_req(GROW_FNS[$urandom_range(0, 2)], rand_value(),
                     POS_W'($urandom_range(0, list_contents.size())));
        end
        send_req(FN_ADD_FRONT, 32'sd11, 7'd0);
        send_req(FN_ADD_BACK, 32'sd12, 7'd0);
        send_req(FN_INSERT, 32'sd13, 7'd64);
        send_req(FN_INSERT, 32'sd14, 7'd65);
        send_req(FN_INSERT, 32'sd15, 7'd127);
        send_req(FN_READ, '0, 7'd63);
        send_req(FN_READ, '0, 7'd64);
        send_req(FN_REMOVE_BACK, '0, 7'd0);
        send_req(FN_INSERT, 32'sd16, 7'd63);
        send_req(FN_REMOVE_FRONT, '0, 7'd0);
        send_req(FN_READ, '0, 7'd0);
    endtask

    task automatic test_backpressure();
        send_gaps_en = 1'b0;
        rsp_stall_en = 1'b0;
        while (list_contents.size() < 24) send_req(FN_ADD_BACK, rand_value(), 7'd0);
        hold_left = 400;
        repeat (30) begin
            send_req($urandom_range(0, 1) ? FN_READ : FN_INSERT, rand_value(),
                     POS_W'($urandom_range(0, list_contents.size() - 1)));
        end
    endtask

    task automatic test_random_traffic(input int unsigned n, input int unsigned grow_pct,
                                       input bit sender_idle, input bit sink_stall);
        logic [FUNC_W-1:0] fn;
        int unsigned       len;
        send_gaps_en = sender_idle;
        rsp_stall_en = sink_stall;
        repeat (n) begin
            len = list_contents.size();
            if ($urandom_range(0, 99) < 3) begin
                fn = $urandom_range(0, 1) ? FN_RSVD_A : FN_RSVD_B;
            end else if ($urandom_range(0, 99) < grow_pct) begin
                fn = GROW_FNS[$urandom_range(0, 2)];
            end else begin
                fn = SHRINK_FNS[$urandom_range(0, 3)];
            end
            send_req(fn, rand_value(), rand_pos((fn == FN_READ && len > 0) ? len - 1 : len));
        end
    endtask

    initial begin
        err_count    = 0;
        hold_left    = 0;
        burst_left   = 0;
        send_gaps_en = 1'b0;
        rsp_stall_en = 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FN_ADD_FRONT;
        req_ch.item_value <= '0;
        req_ch.position   <= '0;
        i_rst_n           <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_insert_positions();
        test_random_traffic(100, 75, 1'b1, 1'b1);
        test_random_traffic(60, 50, 1'b0, 1'b0);
        test_full_store();
        test_backpressure();
        test_random_traffic(120, 50, 1'b1, 1'b1);
        test_random_traffic(120, 25, 1'b1, 1'b0);

        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ille_pkg.sv
hw/rtl/ille_req_if.sv
hw/rtl/ille_rsp_if.sv
hw/rtl/ille_cell.sv
hw/rtl/ille_ctrl.sv
hw/rtl/indexed_linked_list_engine_unit.sv
hw/rtl/ille_checker.sv
sim/tb_indexed_linked_list_engine_unit.sv
